/* rtl/core/szoc_pkg.sv */
package szoc_pkg;

    // Field and storage widths
    localparam int CHAN_BITS    = 3;
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 32;
    localparam int SUM_BITS     = SAMPLE_BITS + 12;
    localparam int NUM_BITS     = SUM_BITS + 2;
    localparam int CC_BITS      = 4;
    localparam int FRAME_BITS   = 13;
    localparam int DIV_BITS     = 12;
    localparam int CNT_BITS     = 6;
    localparam int CFG_BITS     = 13;

    // Calibration limits
    localparam int MAX_FRAMES = 4096;
    localparam int MIN_FILTER = 2;

    localparam logic [CC_BITS-1:0]    CC_RESET   = CC_BITS'(6);
    localparam logic [FRAME_BITS-1:0] FS_RESET   = FRAME_BITS'(100);
    localparam logic [FRAME_BITS-1:0] FS_LOW     = FRAME_BITS'(MIN_FILTER + 1);
    localparam logic [FRAME_BITS-1:0] FS_HIGH    = FRAME_BITS'(MAX_FRAMES);
    localparam logic [CC_BITS-1:0]    CC_HIGH    = CC_BITS'(MAX_CHANNELS);
    localparam logic [CNT_BITS-1:0]   DIV_LAST   = CNT_BITS'(NUM_BITS - 1);

    // Configuration register indexes
    localparam logic CFG_CHANNEL_COUNT  = 1'b0;
    localparam logic CFG_FILTER_SAMPLES = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_NUM1,
        ST_NUM2,
        ST_DSET,
        ST_DIV,
        ST_DEND,
        ST_OUT
    } state_t;

    // Datapath enables driven by the sequencer
    typedef struct packed {
        logic accept;
        logic acc;
        logic num1;
        logic num2;
        logic dset;
        logic dstep;
        logic dend;
        logic out_load;
    } ctl_t;

endpackage

/* rtl/core/sensor_zero_offset_calibration.sv */
// Channel   Direction  Handshake               Payload
// s_axis    in         s_axis_tvalid/tready    tdata: sample; tuser: channel
// m_axis    out        m_axis_tvalid/tready    tdata: value, offset;
//                                              tuser: out_channel, offset_valid, calibrated
// cfg       in         cfg_we                  cfg_addr, cfg_wdata
//
// An ordinary request passes through accept, update and output load. On the final
// calibration frame it also passes through the numerator and divider set-up steps and the
// shared restoring divider, which retires one quotient bit per cycle over 46 bits.
// The input is ready only in idle; a result waiting at the output does not block
// the next accept, only the load of the following result.
// Reset is asynchronous and active low; it restarts calibration at frame one.
module sensor_zero_offset_calibration
(
    input  logic        clk,
    input  logic        rst_n,
    // cfg
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [szoc_pkg::CFG_BITS-1:0] cfg_wdata,
    // request in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample
    input  logic [2:0]  s_axis_tuser,   // [2:0] channel
    // result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] value, [63:32] offset
    output logic [4:0]  m_axis_tuser    // [2:0] out_channel, [3] offset_valid, [4] calibrated
);

    localparam int SB = szoc_pkg::SAMPLE_BITS;
    localparam int NB = szoc_pkg::NUM_BITS;
    localparam int UB = szoc_pkg::SUM_BITS;
    localparam int DB = szoc_pkg::DIV_BITS;

    // Configuration and sequencing state
    logic [szoc_pkg::CC_BITS-1:0]    cc_reg;
    logic [szoc_pkg::FRAME_BITS-1:0] fs_reg;
    logic [szoc_pkg::FRAME_BITS-1:0] frame_reg, frame_next;
    logic                            done_reg, done_next;
    szoc_pkg::state_t                state_reg, state_next;
    szoc_pkg::ctl_t                  ctl;

    // Per-channel storage
    logic [UB-1:0] sum_mem_reg    [szoc_pkg::MAX_CHANNELS];
    logic [SB-1:0] min_mem_reg    [szoc_pkg::MAX_CHANNELS];
    logic [SB-1:0] max_mem_reg    [szoc_pkg::MAX_CHANNELS];
    logic [SB-1:0] offset_mem_reg [szoc_pkg::MAX_CHANNELS];

    // Request holding and shared arithmetic registers
    logic [szoc_pkg::CHAN_BITS-1:0] ch_reg;
    logic [SB-1:0]                  sample_reg;
    logic [SB-1:0]                  value_reg;
    logic [SB-1:0]                  offset_reg;
    logic                           ovalid_reg;
    logic                           calib_reg;
    logic [NB-1:0]                  num_reg;
    logic [NB-1:0]                  quo_reg;
    logic [DB-1:0]                  rem_reg;
    logic [DB-1:0]                  dvsr_reg;
    logic                           neg_reg;
    logic [szoc_pkg::CNT_BITS-1:0]  cnt_reg;

    // Output register
    logic                           m_valid_reg;
    logic [szoc_pkg::CHAN_BITS-1:0] out_ch_reg;
    logic [SB-1:0]                  out_value_reg;
    logic [SB-1:0]                  out_offset_reg;
    logic                           out_ovalid_reg;
    logic                           out_calib_reg;

    logic                            out_free;
    logic [szoc_pkg::CC_BITS-1:0]    cc_eff;
    logic [szoc_pkg::FRAME_BITS-1:0] fs_eff;
    logic                            calib_now;
    logic                            final_now;
    logic                            first_now;
    logic                            frame_end;
    logic [SB:0]                     diff;
    logic [SB-1:0]                   diff_sat;
    logic [UB-1:0]                   sum_add;
    logic [SB:0]                     shifted;
    logic                            ge;
    logic [DB-1:0]                   rem_step;
    logic                            mag_hi;
    logic [SB-1:0]                   quo_sat;

    assign out_free = !m_valid_reg || m_axis_tready;

    // Clamp configuration to the supported ranges
    always_comb
    begin
        if (cc_reg == '0)
            cc_eff = szoc_pkg::CC_BITS'(1);
        else if (cc_reg > szoc_pkg::CC_HIGH)
            cc_eff = szoc_pkg::CC_HIGH;
        else
            cc_eff = cc_reg;

        if (fs_reg < szoc_pkg::FS_LOW)
            fs_eff = szoc_pkg::FS_LOW;
        else if (fs_reg > szoc_pkg::FS_HIGH)
            fs_eff = szoc_pkg::FS_HIGH;
        else
            fs_eff = fs_reg;
    end

    // Frame status of the held request
    assign calib_now = done_reg || (frame_reg > fs_eff);
    assign final_now = (frame_reg == fs_eff);
    assign first_now = (frame_reg == szoc_pkg::FRAME_BITS'(1));
    assign frame_end = ({1'b0, ch_reg} == (cc_eff - szoc_pkg::CC_BITS'(1)));

    // Corrected sample, saturated
    assign diff = {sample_reg[SB-1], sample_reg}
                - {offset_mem_reg[ch_reg][SB-1], offset_mem_reg[ch_reg]};
    always_comb
    begin
        if (diff[SB] != diff[SB-1])
            diff_sat = diff[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        else
            diff_sat = diff[SB-1:0];
    end

    // Running sum with the sign-extended sample
    assign sum_add = sum_mem_reg[ch_reg] + {{(UB-SB){sample_reg[SB-1]}}, sample_reg};

    // One restoring divide step
    assign shifted  = {{(SB-DB){1'b0}}, rem_reg, quo_reg[NB-1]};
    assign ge       = shifted >= {{(SB-DB+1){1'b0}}, dvsr_reg};
    assign rem_step = ge ? DB'(shifted - {{(SB-DB+1){1'b0}}, dvsr_reg}) : shifted[DB-1:0];

    // Signed quotient, saturated to the sample range
    assign mag_hi = neg_reg
                  ? ((|quo_reg[NB-1:SB]) || (quo_reg[SB-1] && (|quo_reg[SB-2:0])))
                  : ((|quo_reg[NB-1:SB]) || quo_reg[SB-1]);
    always_comb
    begin
        if (mag_hi)
            quo_sat = neg_reg ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        else
            quo_sat = neg_reg ? (~quo_reg[SB-1:0] + SB'(1)) : quo_reg[SB-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            szoc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = szoc_pkg::ST_ACC;
            end
            szoc_pkg::ST_ACC:
            begin
                if (!calib_now && final_now)
                    state_next = szoc_pkg::ST_NUM1;
                else
                    state_next = szoc_pkg::ST_OUT;
            end
            szoc_pkg::ST_NUM1: state_next = szoc_pkg::ST_NUM2;
            szoc_pkg::ST_NUM2: state_next = szoc_pkg::ST_DSET;
            szoc_pkg::ST_DSET: state_next = szoc_pkg::ST_DIV;
            szoc_pkg::ST_DIV:
            begin
                if (cnt_reg == szoc_pkg::DIV_LAST)
                    state_next = szoc_pkg::ST_DEND;
            end
            szoc_pkg::ST_DEND: state_next = szoc_pkg::ST_OUT;
            szoc_pkg::ST_OUT:
            begin
                if (out_free)
                    state_next = szoc_pkg::ST_IDLE;
            end
            default: state_next = szoc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        ctl           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            szoc_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ctl.accept    = s_axis_tvalid;
            end
            szoc_pkg::ST_ACC:  ctl.acc      = 1'b1;
            szoc_pkg::ST_NUM1: ctl.num1     = 1'b1;
            szoc_pkg::ST_NUM2: ctl.num2     = 1'b1;
            szoc_pkg::ST_DSET: ctl.dset     = 1'b1;
            szoc_pkg::ST_DIV:  ctl.dstep    = 1'b1;
            szoc_pkg::ST_DEND: ctl.dend     = 1'b1;
            szoc_pkg::ST_OUT:  ctl.out_load = out_free;
            default: ctl = '0;
        endcase
    end

    // Frame counter and calibration flag
    always_comb
    begin
        frame_next = frame_reg;
        done_next  = done_reg;
        if (ctl.acc && !calib_now && frame_end)
        begin
            if (final_now)
                done_next = 1'b1;
            else
                frame_next = frame_reg + szoc_pkg::FRAME_BITS'(1);
        end
    end

    // Control state, configuration, running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= szoc_pkg::ST_IDLE;
            cc_reg      <= szoc_pkg::CC_RESET;
            fs_reg      <= szoc_pkg::FS_RESET;
            frame_reg   <= szoc_pkg::FRAME_BITS'(1);
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < szoc_pkg::MAX_CHANNELS; i++)
                sum_mem_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            frame_reg <= frame_next;
            done_reg  <= done_next;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    szoc_pkg::CFG_CHANNEL_COUNT:  cc_reg <= cfg_wdata[szoc_pkg::CC_BITS-1:0];
                    szoc_pkg::CFG_FILTER_SAMPLES: fs_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // Initialize on the first frame, accumulate after
            if (ctl.acc && !calib_now)
            begin
                if (first_now)
                    sum_mem_reg[ch_reg] <= {{(UB-SB){sample_reg[SB-1]}}, sample_reg};
                else
                    sum_mem_reg[ch_reg] <= sum_add;
            end

            // Hold the result until taken
            if (ctl.out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Payload registers and per-channel extremes and offsets
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            ch_reg     <= s_axis_tuser;
            sample_reg <= s_axis_tdata;
        end

        if (ctl.acc)
        begin
            calib_reg  <= calib_now;
            ovalid_reg <= 1'b0;
            offset_reg <= '0;
            value_reg  <= calib_now ? diff_sat : sample_reg;
            if (!calib_now)
            begin
                if (first_now || ($signed(sample_reg) < $signed(min_mem_reg[ch_reg])))
                    min_mem_reg[ch_reg] <= sample_reg;
                if (first_now || ($signed(sample_reg) > $signed(max_mem_reg[ch_reg])))
                    max_mem_reg[ch_reg] <= sample_reg;
            end
        end

        // Numerator: sum - max - min
        if (ctl.num1)
            num_reg <= {{(NB-UB){sum_mem_reg[ch_reg][UB-1]}}, sum_mem_reg[ch_reg]}
                     - {{(NB-SB){max_mem_reg[ch_reg][SB-1]}}, max_mem_reg[ch_reg]};
        if (ctl.num2)
            num_reg <= num_reg
                     - {{(NB-SB){min_mem_reg[ch_reg][SB-1]}}, min_mem_reg[ch_reg]};

        // Load divider with magnitude and divisor
        if (ctl.dset)
        begin
            neg_reg  <= num_reg[NB-1];
            quo_reg  <= num_reg[NB-1] ? (~num_reg + NB'(1)) : num_reg;
            rem_reg  <= '0;
            dvsr_reg <= DB'(fs_eff - szoc_pkg::FRAME_BITS'(szoc_pkg::MIN_FILTER));
            cnt_reg  <= '0;
        end

        // Advance one quotient bit
        if (ctl.dstep)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[NB-2:0], ge};
            cnt_reg <= cnt_reg + szoc_pkg::CNT_BITS'(1);
        end

        // Store the new offset
        if (ctl.dend)
        begin
            offset_reg             <= quo_sat;
            offset_mem_reg[ch_reg] <= quo_sat;
            ovalid_reg             <= 1'b1;
        end

        if (ctl.out_load)
        begin
            out_ch_reg     <= ch_reg;
            out_value_reg  <= value_reg;
            out_offset_reg <= offset_reg;
            out_ovalid_reg <= ovalid_reg;
            out_calib_reg  <= calib_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_offset_reg, out_value_reg};
    assign m_axis_tuser  = {out_calib_reg, out_ovalid_reg, out_ch_reg};

`ifndef SYNTHESIS
    // Divider finishes after its last quotient bit
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == szoc_pkg::ST_DIV && cnt_reg == szoc_pkg::DIV_LAST)
        |=> (state_reg == szoc_pkg::ST_DEND))
        else $error("divider did not finish after last quotient bit");

    // An offset is only produced on an uncalibrated request
    a_offset_uncal: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |-> !m_axis_tuser[4])
        else $error("offset emitted on a calibrated result");

    // Calibration, once complete, stays complete
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("calibration flag dropped");

    // Frame counter never reaches zero
    a_frame_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        frame_reg != '0)
        else $error("frame counter is zero");
`endif

endmodule
